/* hdl/bitmap_page_allocator_core_defines.svh */
// Assertion macros for the bitmap page allocator core.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication on clock, disabled in reset.
`define BPA_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on clock, disabled in reset.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/bpa_pkg.sv */
// Types and constants shared by the bitmap page allocator files.
package bpa_pkg;

   localparam int BITMAP_BYTES_DEF = 4096;
   localparam int SPARE_DEPTH_DEF  = 32;
   localparam int PAGE_NUM_LIMIT   = 32768;

   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 12;
   localparam int BYTE_W     = 8;
   localparam int PAGE_W     = 15;
   localparam int TOTAL_W    = 16;
   localparam int REFILL_W   = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PAGES  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFILL_COUNT = 1'd1;

   localparam logic [TOTAL_W-1:0]  TOTAL_PAGES_RST  = 16'd32768;
   localparam logic [REFILL_W-1:0] REFILL_COUNT_RST = 6'd20;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] byte_index;
      logic [BYTE_W-1:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page_number;
      logic              found;
      logic [BYTE_W-1:0] read_byte;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_WAIT,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_BIT,
      ST_POP_RD,
      ST_POP_WAIT,
      ST_RESP
   } state_type;

endpackage

/* hdl/bpa_chan_if.sv */
// Valid/ready channel carrying one item of a given payload type.
interface bpa_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/bitmap_page_allocator_core.sv */
// Bitmap page allocator core: allocation bitmap in RAM, spare-page FIFO, refill scanner.
// After reset the core sweeps the bitmap RAM to zero, one byte per cycle, and takes no item
// until that is done; CSR writes are taken at any time. A byte write goes from idle straight
// to the response state, a byte read first passes the read-wait state, and a capture that
// pops a waiting spare page passes the pop read and pop wait states. A capture that finds
// the spare list empty first runs a refill scan from byte 0: each scanned byte is read in
// the scan read and scan wait states and written back in the scan bit state, which repeats
// once for every free page taken from it. The single bitmap RAM port pair sets the scan's
// pace. One item is worked at a time; a finished result sits in the output register while
// the next item is taken.
`include "bitmap_page_allocator_core_defines.svh"

module bitmap_page_allocator_core #(
   parameter int BITMAP_BYTES = bpa_pkg::BITMAP_BYTES_DEF,
   parameter int SPARE_DEPTH  = bpa_pkg::SPARE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   bpa_chan_if.sink                        req_if,
   bpa_chan_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bpa_pkg::*;

   localparam int AW        = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
   localparam int SA_W      = AW + 1;
   localparam int HW        = (SPARE_DEPTH > 1) ? $clog2(SPARE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(SPARE_DEPTH + 1);
   localparam int CMP_W     = ((SA_W + 3 > TOTAL_W) ? SA_W + 3 : TOTAL_W) + 1;
   localparam int IDX_EXT_W = (AW > INDEX_W) ? AW : INDEX_W;
   localparam int BYTE_PAGES = BITMAP_BYTES * 8;
   localparam int LIM_CAP   = (BYTE_PAGES < PAGE_NUM_LIMIT) ? BYTE_PAGES : PAGE_NUM_LIMIT;

   function automatic logic [2:0] first_free(input logic [7:0] v);
      logic [2:0] pos;
      pos = '0;
      for (int i = 7; i >= 0; i--) begin
         if (v[7-i]) begin
            pos = 3'(i);
         end
      end
      return pos;
   endfunction

   state_type state_ff, state_in;
   logic [SA_W-1:0]     scan_addr_ff, scan_addr_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [HW-1:0]       head_ff, head_in;
   logic [HW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   rsp_type             res_ff, res_in;
   rsp_type             out_ff, out_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]  total_pages_ff, total_pages_in;
   logic [REFILL_W-1:0] refill_count_ff, refill_count_in;

   logic [BYTE_W-1:0] bitmap_mem [BITMAP_BYTES];
   logic [BYTE_W-1:0] bm_rdata_ff;
   logic              bm_we;
   logic [AW-1:0]     bm_waddr;
   logic [BYTE_W-1:0] bm_wdata;
   logic [AW-1:0]     bm_raddr;

   logic [PAGE_W-1:0] spare_mem [SPARE_DEPTH];
   logic [PAGE_W-1:0] sp_rdata_ff;
   logic              sp_we;
   logic [PAGE_W-1:0] sp_wdata;

   logic                 req_fire;
   logic                 idx_in_range;
   logic [IDX_EXT_W-1:0] idx_ext;
   logic [AW-1:0]        idx_addr;
   logic [TOTAL_W-1:0]   lim;
   logic [CMP_W-1:0]     lim_ext;
   logic [CMP_W-1:0]     byte_base;
   logic [CNT_W-1:0]     want;
   logic                 scan_done;
   logic [BYTE_W-1:0]    elig;
   logic [BYTE_W-1:0]    cand;
   logic                 take;
   logic [2:0]           bit_pos;
   logic [BYTE_W-1:0]    bit_mask;
   logic                 clear_last;
   logic                 rsp_free;
   logic [HW-1:0]        head_next;
   logic [HW-1:0]        wr_ptr_next;

   assign req_fire     = req_if.valid && req_if.ready;
   assign idx_in_range = 32'(req_if.payload.byte_index) < BITMAP_BYTES;
   assign idx_ext      = IDX_EXT_W'(req_if.payload.byte_index);
   assign idx_addr     = idx_ext[AW-1:0];

   assign lim       = (total_pages_ff > TOTAL_W'(LIM_CAP)) ? TOTAL_W'(LIM_CAP) : total_pages_ff;
   assign lim_ext   = CMP_W'(lim);
   assign byte_base = CMP_W'({scan_addr_ff, 3'b000});
   assign want      = ({1'b0, refill_count_ff} > (REFILL_W + 1)'(SPARE_DEPTH)) ?
                      CNT_W'(SPARE_DEPTH) : CNT_W'(refill_count_ff);
   assign scan_done = (byte_base >= lim_ext) || (count_ff >= want);

   always_comb begin
      if (byte_base + CMP_W'(8) <= lim_ext) begin
         elig = 8'hFF;
      end else if (byte_base < lim_ext) begin
         elig = ~(8'hFF >> lim[2:0]);
      end else begin
         elig = 8'h00;
      end
   end

   assign cand        = ~byte_ff & elig;
   assign take        = (cand != 8'h00) && (count_ff < want);
   assign bit_pos     = first_free(cand);
   assign bit_mask    = 8'h80 >> bit_pos;
   assign clear_last  = scan_addr_ff == SA_W'(BITMAP_BYTES - 1);
   assign rsp_free    = !rsp_valid_ff || rsp_if.ready;
   assign head_next   = (head_ff == HW'(SPARE_DEPTH - 1)) ? '0 : head_ff + HW'(1);
   assign wr_ptr_next = (wr_ptr_ff == HW'(SPARE_DEPTH - 1)) ? '0 : wr_ptr_ff + HW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.payload.cmd)
                  CMD_READ:    state_in = idx_in_range ? ST_READ_WAIT : ST_RESP;
                  CMD_CAPTURE: state_in = (count_ff == '0) ? ST_SCAN_RD : ST_POP_RD;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_READ_WAIT: state_in = ST_RESP;
         ST_SCAN_RD:   state_in = scan_done ? ST_POP_RD : ST_SCAN_WAIT;
         ST_SCAN_WAIT: state_in = ST_SCAN_BIT;
         ST_SCAN_BIT:  state_in = take ? ST_SCAN_BIT : ST_SCAN_RD;
         ST_POP_RD:    state_in = (count_ff == '0) ? ST_RESP : ST_POP_WAIT;
         ST_POP_WAIT:  state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and memory controls
   always_comb begin
      req_if.ready = 1'b0;
      bm_we        = 1'b0;
      bm_waddr     = scan_addr_ff[AW-1:0];
      bm_wdata     = byte_ff;
      bm_raddr     = scan_addr_ff[AW-1:0];
      sp_we        = 1'b0;
      sp_wdata     = PAGE_W'({scan_addr_ff, bit_pos});
      case (state_ff)
         ST_CLEAR: begin
            bm_we    = 1'b1;
            bm_wdata = '0;
         end
         ST_IDLE: begin
            req_if.ready = 1'b1;
            bm_raddr     = idx_addr;
            bm_waddr     = idx_addr;
            bm_wdata     = req_if.payload.byte_value;
            bm_we        = req_fire && (req_if.payload.cmd == CMD_WRITE) && idx_in_range;
         end
         ST_SCAN_BIT: begin
            bm_we = !take;
            sp_we = take;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      scan_addr_in    = scan_addr_ff;
      byte_in         = byte_ff;
      head_in         = head_ff;
      wr_ptr_in       = wr_ptr_ff;
      count_in        = count_ff;
      res_in          = res_ff;
      out_in          = out_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      total_pages_in  = total_pages_ff;
      refill_count_in = refill_count_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_TOTAL_PAGES:  total_pages_in  = csr_wdata[TOTAL_W-1:0];
            CSR_REFILL_COUNT: refill_count_in = csr_wdata[REFILL_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            scan_addr_in = clear_last ? '0 : scan_addr_ff + SA_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               res_in       = '0;
               scan_addr_in = '0;
               wr_ptr_in    = head_ff;
            end
         end
         ST_READ_WAIT: begin
            res_in.read_byte = bm_rdata_ff;
         end
         ST_SCAN_WAIT: begin
            byte_in = bm_rdata_ff;
         end
         ST_SCAN_BIT: begin
            if (take) begin
               byte_in   = byte_ff | bit_mask;
               count_in  = count_ff + CNT_W'(1);
               wr_ptr_in = wr_ptr_next;
            end else begin
               scan_addr_in = scan_addr_ff + SA_W'(1);
            end
         end
         ST_POP_WAIT: begin
            res_in.page_number = sp_rdata_ff;
            res_in.found       = 1'b1;
            head_in            = head_next;
            count_in           = count_ff - CNT_W'(1);
         end
         ST_RESP: begin
            if (rsp_free) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         scan_addr_ff    <= '0;
         head_ff         <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         total_pages_ff  <= TOTAL_PAGES_RST;
         refill_count_ff <= REFILL_COUNT_RST;
      end else begin
         state_ff        <= state_in;
         scan_addr_ff    <= scan_addr_in;
         head_ff         <= head_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
         total_pages_ff  <= total_pages_in;
         refill_count_ff <= refill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      wr_ptr_ff <= wr_ptr_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bitmap_mem[bm_waddr] <= bm_wdata;
      end
      bm_rdata_ff <= bitmap_mem[bm_raddr];
   end

   always_ff @(posedge clock) begin
      if (sp_we) begin
         spare_mem[wr_ptr_ff] <= sp_wdata;
      end
      sp_rdata_ff <= spare_mem[head_ff];
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = out_ff;

   `BPA_ASSERT_HOLDS(a_scan_within_want, state_ff == ST_SCAN_BIT, count_ff <= want, "spare count passed refill target")
   `BPA_ASSERT_HOLDS(a_scan_addr_range, state_ff == ST_SCAN_WAIT, 32'(scan_addr_ff) < BITMAP_BYTES, "scan read past bitmap end")
   `BPA_ASSERT_NEXT(a_pop_count, state_ff == ST_POP_WAIT, count_ff == $past(count_ff) - CNT_W'(1), "pop did not drop spare count")
   `BPA_ASSERT_HOLDS(a_rsp_from_resp, $rose(rsp_valid_ff), $past(state_ff == ST_RESP), "result item raised outside response state")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the bitmap page allocator core: directed and random traffic.
module testbench;
   import bpa_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 40000;
   localparam int HOLD_AT    = 600;
   localparam int HOLD_LEN   = 300;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bpa_chan_if #(.payload_type(req_type)) req_ch ();
   bpa_chan_if #(.payload_type(rsp_type)) rsp_ch ();

   bitmap_page_allocator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [BYTE_W-1:0]   bitmap_model [BITMAP_BYTES_DEF];
   logic [PAGE_W-1:0]   spare_ring [SPARE_DEPTH_DEF];
   int unsigned         ring_head;
   int unsigned         ring_fill;
   logic [TOTAL_W-1:0]  total_cfg;
   logic [REFILL_W-1:0] refill_cfg;

   req_type req_backlog [$];
   rsp_type due_responses [$];

   bit calm;
   int send_gap;
   int recv_gap;
   int hold_left;
   bit held;
   int idle_cycles;
   int mismatches;
   int items_sent;
   int results_checked;
   int pages_granted;
   int captures_empty;
   int settings_used;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
               what, got, want, results_checked);
   endtask

   function automatic void refill_spares();
      int unsigned lim;
      int unsigned want;
      int unsigned p;
      logic [BYTE_W-1:0] mask;
      lim = 32'(total_cfg);
      if (lim > BITMAP_BYTES_DEF * 8) lim = BITMAP_BYTES_DEF * 8;
      if (lim > PAGE_NUM_LIMIT) lim = PAGE_NUM_LIMIT;
      want = (refill_cfg > SPARE_DEPTH_DEF) ? SPARE_DEPTH_DEF : 32'(refill_cfg);
      for (p = 0; p < lim && ring_fill < want; p++) begin
         mask = 8'h80 >> p[2:0];
         if ((bitmap_model[p >> 3] & mask) == 0) begin
            bitmap_model[p >> 3] = bitmap_model[p >> 3] | mask;
            spare_ring[(ring_head + ring_fill) % SPARE_DEPTH_DEF] = p[PAGE_W-1:0];
            ring_fill++;
         end
      end
   endfunction

   function automatic rsp_type bitmap_response(req_type it);
      rsp_type r;
      r = '0;
      case (it.cmd)
         CMD_WRITE: bitmap_model[it.byte_index] = it.byte_value;
         CMD_READ: r.read_byte = bitmap_model[it.byte_index];
         CMD_CAPTURE: begin
            if (ring_fill == 0) refill_spares();
            if (ring_fill > 0) begin
               r.page_number = spare_ring[ring_head];
               r.found = 1'b1;
               ring_head = (ring_head + 1) % SPARE_DEPTH_DEF;
               ring_fill--;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due = bitmap_response(req_ch.payload);
            due_responses.push_back(due);
            items_sent++;
            if (req_ch.payload.cmd == CMD_CAPTURE) begin
               if (due.found) pages_granted++;
               else captures_empty++;
            end
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the item until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 6);
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.payload <= req_backlog.pop_front();
               req_ch.valid <= 1'b1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_responses.size() == 0) begin
               report_mismatch("result with nothing due", int'(rsp_ch.payload), 0);
            end else begin
               want = due_responses.pop_front();
               if (rsp_ch.payload.page_number !== want.page_number)
                  report_mismatch("page_number", int'(rsp_ch.payload.page_number),
                                  int'(want.page_number));
               if (rsp_ch.payload.found !== want.found)
                  report_mismatch("found", int'(rsp_ch.payload.found), int'(want.found));
               if (rsp_ch.payload.read_byte !== want.read_byte)
                  report_mismatch("read_byte", int'(rsp_ch.payload.read_byte),
                                  int'(want.read_byte));
            end
            results_checked++;
         end
         if (!held && results_checked >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_ch.valid || due_responses.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_config(logic [TOTAL_W-1:0] pages, logic [REFILL_W-1:0] refill);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_TOTAL_PAGES;
      csr_wdata <= pages;
      @(posedge clock);
      csr_index <= CSR_REFILL_COUNT;
      csr_wdata <= {{(CSR_DATA_W-REFILL_W){1'b0}}, refill};
      @(posedge clock);
      csr_we <= 1'b0;
      total_cfg  = pages;
      refill_cfg = refill;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic add_item(logic [CMD_W-1:0] cmd, int idx, int val);
      req_type it;
      it.cmd        = cmd;
      it.byte_index = idx[INDEX_W-1:0];
      it.byte_value = val[BYTE_W-1:0];
      req_backlog.push_back(it);
   endtask

   // most traffic lands in the first span bytes, writes often free whole bytes
   task automatic run_phase(int pages, int refill, int count, int span);
      int n;
      int r;
      int idx;
      int val;
      wait_idle();
      set_config(pages[TOTAL_W-1:0], refill[REFILL_W-1:0]);
      for (n = 0; n < count; n++) begin
         r = $urandom_range(0, 19);
         if ($urandom_range(0, 7) == 0) idx = $urandom_range(0, BITMAP_BYTES_DEF - 1);
         else idx = $urandom_range(0, span - 1);
         case ($urandom_range(0, 5))
            0, 1: val = 0;
            2: val = 255;
            default: val = $urandom_range(0, 255);
         endcase
         if (r < 8) add_item(CMD_CAPTURE, idx, val);
         else if (r < 14) add_item(CMD_WRITE, idx, val);
         else if (r < 19) add_item(CMD_READ, idx, val);
         else add_item(CMD_UNUSED, idx, val);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TOTAL_PAGES;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      calm = 1'b0;
      foreach (bitmap_model[i]) bitmap_model[i] = '0;
      foreach (spare_ring[i]) spare_ring[i] = '0;
      ring_head = 0;
      ring_fill = 0;
      total_cfg = TOTAL_PAGES_RST;
      refill_cfg = REFILL_COUNT_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // twelve pages, two per refill
      set_config(16'd12, 6'd2);
      add_item(CMD_UNUSED, 4095, 255);
      add_item(CMD_READ, 4095, 0);
      add_item(CMD_WRITE, 4095, 255);
      add_item(CMD_READ, 4095, 0);
      add_item(CMD_CAPTURE, 0, 0);
      add_item(CMD_READ, 0, 0);
      add_item(CMD_WRITE, 0, 0);
      add_item(CMD_CAPTURE, 0, 0);
      add_item(CMD_CAPTURE, 0, 0);
      add_item(CMD_WRITE, 0, 255);
      add_item(CMD_WRITE, 1, 224);
      add_item(CMD_CAPTURE, 0, 0);
      add_item(CMD_CAPTURE, 0, 0);
      add_item(CMD_CAPTURE, 0, 0);
      add_item(CMD_READ, 1, 0);
      // no pages at all
      wait_idle();
      set_config(16'd0, 6'd32);
      add_item(CMD_WRITE, 0, 0);
      add_item(CMD_CAPTURE, 0, 0);
      // empty refill request
      wait_idle();
      set_config(16'd8, 6'd0);
      add_item(CMD_CAPTURE, 0, 0);
      // limit on a byte boundary: byte 1 must stay untouched
      wait_idle();
      set_config(16'd8, 6'd32);
      add_item(CMD_WRITE, 1, 0);
      add_item(CMD_CAPTURE, 0, 0);
      add_item(CMD_READ, 1, 0);
      add_item(CMD_READ, 0, 0);

      run_phase(65535, 32, 150, 64);
      run_phase(32768, 20, 150, 64);
      run_phase(1, 1, 150, 2);
      run_phase(100, 7, 350, 15);
      run_phase(37, 33, 250, 6);
      run_phase(0, 5, 50, 2);
      run_phase(16, 63, 200, 4);
      wait_idle();
      calm = 1'b1;
      run_phase(300, 32, 250, 40);

      wait_idle();
      repeat (20) @(posedge clock);
      if (due_responses.size() != 0)
         report_mismatch("results never returned", due_responses.size(), 0);
      $display("Ran %0d items under %0d register settings, %0d results checked.",
               items_sent, settings_used, results_checked);
      $display("Captures: %0d pages granted, %0d found nothing; %0d mismatches.",
               pages_granted, captures_empty, mismatches);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_chan_if.sv
hdl/bitmap_page_allocator_core.sv
tb/testbench.sv
